/* src/limit_order_matching_defines.svh */
// Assertion macros for the limit order matching block.
// Used by the top level; depends on nothing else.
`ifndef LIMIT_ORDER_MATCHING_DEFINES_SVH
`define LIMIT_ORDER_MATCHING_DEFINES_SVH
`ifndef SYNTHESIS
`define LOM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define LOM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LOM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LOM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* src/lom_pkg.sv */
// Package for the limit order matching block: codes, slot record type, defaults.
// Depends on nothing.
`timescale 1ns / 1ps
package lom_pkg;
    localparam int BOOK_DEPTH_DEF = 32;

    localparam logic [1:0] CMD_BID    = 2'd0;
    localparam logic [1:0] CMD_ASK    = 2'd1;
    localparam logic [1:0] CMD_CANCEL = 2'd2;
    localparam logic [1:0] CMD_BAD    = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_BADCMD  = 2'd3;

    localparam logic KIND_TRADE = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    typedef struct packed {
        logic        is_ask;
        logic [31:0] price;
        logic [31:0] qty;
        logic [30:0] owner;
        logic [31:0] arrival;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);
endpackage

/* src/lom_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module lom_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* src/limit_order_matching.sv */
// Top level of the limit order matching block: command sequencer and book memory.
// Depends on lom_pkg, lom_ram and limit_order_matching_defines.svh.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | to block  | in_valid / in_stall  | cmd, ord_id, limit_price, order_qty
//  out     | from block| out_valid / out_stall| kind, trade_price, trade_qty, ask_id,
//          |           |                      | bid_id, status, last
//
// Steps, from the accepted command to the done word: a bad command goes straight to it,
// a cancel scans the slots for the owner. An insert runs a best-price search and a fill
// per trade, a final search that finds nothing to cross, a walk for the free slot and
// then the done word; every best-price search is a full pass over the RAM read port.
// Reset clears the sequencer, the slot valid bits and the arrival counter at once. A stall
// on the output word holds the sequencer until the output register frees up.
`timescale 1ns / 1ps
`include "limit_order_matching_defines.svh"
module limit_order_matching #(
    parameter int BOOK_DEPTH = lom_pkg::BOOK_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [30:0] ord_id,
    input  logic [31:0] limit_price,
    input  logic [31:0] order_qty,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [31:0] trade_price,
    output logic [31:0] trade_qty,
    output logic [30:0] ask_id,
    output logic [30:0] bid_id,
    output logic [1:0]  status,
    output logic        last
);
    import lom_pkg::*;

    localparam int AW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
    localparam int CW = $clog2(BOOK_DEPTH + 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MCHK  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_MDEC  = 3'd3;
    localparam logic [2:0] S_FILL  = 3'd4;
    localparam logic [2:0] S_FREE  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;
    localparam logic [2:0] S_CSCAN = 3'd7;

    logic [2:0]            state_reg, state_next;
    logic [BOOK_DEPTH-1:0] valid_reg, valid_next;
    logic [31:0]           ctr_reg, ctr_next;
    logic [1:0]            cmd_reg, cmd_next;
    logic [30:0]           id_reg, id_next;
    logic [31:0]           price_reg, price_next;
    logic [31:0]           qty_reg, qty_next;
    logic [CW-1:0]         n_reg, n_next;
    logic [CW-1:0]         scan_reg, scan_next;
    logic [AW-1:0]         free_reg, free_next;
    logic                  found_reg, found_next;
    logic [AW-1:0]         best_idx_reg, best_idx_next;
    slot_t                 best_reg, best_next;
    logic [31:0]           best_age_reg, best_age_next;
    logic [1:0]            dst_reg, dst_next;
    logic [31:0]           dqty_reg, dqty_next;

    logic        ov_reg, ov_next;
    logic        kind_reg, kind_next;
    logic [31:0] tp_reg, tp_next;
    logic [31:0] tq_reg, tq_next;
    logic [30:0] aid_reg, aid_next;
    logic [30:0] bid_reg, bid_next;
    logic [1:0]  st_reg, st_next;
    logic        last_reg, last_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    slot_t         ram_wdata, ram_rdata;

    logic          can_emit;
    logic          inc_is_ask;
    logic [AW-1:0] cmp_idx;
    logic [31:0]   age_i;
    logic [31:0]   fill;
    logic          take;

    lom_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(BOOK_DEPTH)
    ) u_book (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = ov_reg;
    assign kind        = kind_reg;
    assign trade_price = tp_reg;
    assign trade_qty   = tq_reg;
    assign ask_id      = aid_reg;
    assign bid_id      = bid_reg;
    assign status      = st_reg;
    assign last        = last_reg;

    // The output register may be loaded when it is empty or being taken this cycle.
    assign can_emit   = !ov_reg || !out_stall;
    assign inc_is_ask = (cmd_reg == CMD_ASK);

    // The scan issues a read for slot scan_reg and evaluates slot scan_reg - 1, whose
    // data the RAM returns this cycle. Writes happen only in the fill and rest states,
    // never while a scan is reading, so no forwarding path is needed.
    assign ram_raddr = (scan_reg < CW'(BOOK_DEPTH)) ? scan_reg[AW-1:0] : '0;
    assign cmp_idx   = AW'(scan_reg - CW'(1));
    assign age_i     = ctr_reg - ram_rdata.arrival;
    assign fill      = (best_reg.qty < qty_reg) ? best_reg.qty : qty_reg;

    // Price-time priority against the best slot found so far on the resting side.
    always_comb
    begin
        take = 1'b0;
        if (valid_reg[cmp_idx] && (ram_rdata.is_ask == !inc_is_ask))
        begin
            if (!found_reg)
            begin
                take = 1'b1;
            end
            else if (ram_rdata.price != best_reg.price)
            begin
                take = inc_is_ask ? (ram_rdata.price > best_reg.price)
                                  : (ram_rdata.price < best_reg.price);
            end
            else
            begin
                take = (age_i > best_age_reg);
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        ctr_next      = ctr_reg;
        cmd_next      = cmd_reg;
        id_next       = id_reg;
        price_next    = price_reg;
        qty_next      = qty_reg;
        n_next        = n_reg;
        scan_next     = scan_reg;
        free_next     = free_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        best_age_next = best_age_reg;
        dst_next      = dst_reg;
        dqty_next     = dqty_reg;
        ov_next       = ov_reg && out_stall;
        kind_next     = kind_reg;
        tp_next       = tp_reg;
        tq_next       = tq_reg;
        aid_next      = aid_reg;
        bid_next      = bid_reg;
        st_next       = st_reg;
        last_next     = last_reg;
        ram_we        = 1'b0;
        ram_waddr     = best_idx_reg;
        ram_wdata     = best_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cmd;
                    id_next    = ord_id;
                    price_next = limit_price;
                    qty_next   = order_qty;
                    n_next     = '0;
                    scan_next  = '0;
                    dqty_next  = '0;
                    case (cmd)
                        CMD_BAD:
                        begin
                            dst_next   = ST_BADCMD;
                            state_next = S_DONE;
                        end
                        CMD_CANCEL:
                        begin
                            state_next = S_CSCAN;
                        end
                        default:
                        begin
                            state_next = S_MCHK;
                        end
                    endcase
                end
            end
            S_MCHK:
            begin
                scan_next  = '0;
                found_next = 1'b0;
                free_next  = '0;
                if ((qty_reg == 32'd0) || (n_reg == CW'(BOOK_DEPTH)))
                begin
                    state_next = S_FREE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if ((scan_reg != '0) && take)
                begin
                    found_next    = 1'b1;
                    best_idx_next = cmp_idx;
                    best_next     = ram_rdata;
                    best_age_next = age_i;
                end
                if (scan_reg == CW'(BOOK_DEPTH))
                begin
                    state_next = S_MDEC;
                end
                else
                begin
                    scan_next = scan_reg + CW'(1);
                end
            end
            S_MDEC:
            begin
                if (!found_reg || (inc_is_ask ? (best_reg.price < price_reg)
                                              : (best_reg.price > price_reg)))
                begin
                    state_next = S_FREE;
                end
                else
                begin
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                if (can_emit)
                begin
                    ov_next       = 1'b1;
                    kind_next     = KIND_TRADE;
                    tp_next       = best_reg.price;
                    tq_next       = fill;
                    aid_next      = inc_is_ask ? id_reg : best_reg.owner;
                    bid_next      = inc_is_ask ? best_reg.owner : id_reg;
                    st_next       = ST_OK;
                    last_next     = 1'b0;
                    ram_we        = 1'b1;
                    ram_wdata.qty = best_reg.qty - fill;
                    if (best_reg.qty == fill)
                    begin
                        valid_next[best_idx_reg] = 1'b0;
                    end
                    qty_next   = qty_reg - fill;
                    n_next     = n_reg + CW'(1);
                    state_next = S_MCHK;
                end
            end
            S_FREE:
            begin
                // Walks the valid bits one slot a cycle for the lowest free slot.
                if (qty_reg == 32'd0)
                begin
                    dst_next   = ST_OK;
                    state_next = S_DONE;
                end
                else if (!valid_reg[free_reg])
                begin
                    ram_we            = 1'b1;
                    ram_waddr         = free_reg;
                    ram_wdata.is_ask  = inc_is_ask;
                    ram_wdata.price   = price_reg;
                    ram_wdata.qty     = qty_reg;
                    ram_wdata.owner   = id_reg;
                    ram_wdata.arrival = ctr_reg;
                    valid_next[free_reg] = 1'b1;
                    ctr_next   = ctr_reg + 32'd1;
                    dst_next   = ST_OK;
                    dqty_next  = qty_reg;
                    state_next = S_DONE;
                end
                else if (free_reg == AW'(BOOK_DEPTH - 1))
                begin
                    dst_next   = ST_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    free_next = free_reg + AW'(1);
                end
            end
            S_CSCAN:
            begin
                if ((scan_reg != '0) && valid_reg[cmp_idx] && (ram_rdata.owner == id_reg))
                begin
                    valid_next[cmp_idx] = 1'b0;
                    dst_next   = ST_OK;
                    state_next = S_DONE;
                end
                else if (scan_reg == CW'(BOOK_DEPTH))
                begin
                    dst_next   = ST_UNKNOWN;
                    state_next = S_DONE;
                end
                else
                begin
                    scan_next = scan_reg + CW'(1);
                end
            end
            S_DONE:
            begin
                if (can_emit)
                begin
                    ov_next    = 1'b1;
                    kind_next  = KIND_DONE;
                    tp_next    = '0;
                    tq_next    = dqty_reg;
                    aid_next   = '0;
                    bid_next   = '0;
                    st_next    = dst_reg;
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            ctr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            ctr_reg   <= ctr_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        id_reg       <= id_next;
        price_reg    <= price_next;
        qty_reg      <= qty_next;
        n_reg        <= n_next;
        scan_reg     <= scan_next;
        free_reg     <= free_next;
        found_reg    <= found_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        best_age_reg <= best_age_next;
        dst_reg      <= dst_next;
        dqty_reg     <= dqty_next;
        kind_reg     <= kind_next;
        tp_reg       <= tp_next;
        tq_reg       <= tq_next;
        aid_reg      <= aid_next;
        bid_reg      <= bid_next;
        st_reg       <= st_next;
        last_reg     <= last_next;
    end

    // Book memory is written only when a fill updates a slot or a remainder rests.
    `LOM_ASSERT_IMP(a_we_state, clk, rst_n, ram_we, (state_reg == S_FILL) || (state_reg == S_FREE))
    // A command never produces more trades than the book has slots.
    `LOM_ASSERT_IMP(a_trade_cap, clk, rst_n, state_reg != S_IDLE, n_reg <= CW'(BOOK_DEPTH))
    // A done word always ends the command and returns the sequencer to idle.
    `LOM_ASSERT_NXT(a_done_idle, clk, rst_n, (state_reg == S_DONE) && can_emit, (state_reg == S_IDLE) && out_valid && last && kind)
endmodule

/* sim/tb_limit_order_matching.sv */
// Self-checking testbench for limit_order_matching: random and directed order traffic
// with an in-bench price-time matching predictor. Depends on lom_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb_limit_order_matching;
    import lom_pkg::*;

    localparam int DEPTH      = BOOK_DEPTH_DEF;
    localparam int ITEM_GOAL  = 460;
    // A full sweep can produce 33 words, each after a full search of the book, and every
    // one may wait out long receiver stalls, so the idle limit is set generously.
    localparam int IDLE_LIMIT = 40000;

    typedef struct {
        logic [1:0]  op;
        logic [30:0] id;
        logic [31:0] price;
        logic [31:0] qty;
        int          phase;
    } order_t;

    typedef struct {
        logic        kind;
        logic [31:0] price;
        logic [31:0] qty;
        logic [30:0] ask;
        logic [30:0] bid;
        logic [1:0]  st;
        logic        last;
    } report_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  cmd;
    logic [30:0] ord_id;
    logic [31:0] limit_price;
    logic [31:0] order_qty;
    logic        out_valid;
    logic        out_stall;
    logic        kind;
    logic [31:0] trade_price;
    logic [31:0] trade_qty;
    logic [30:0] ask_id;
    logic [30:0] bid_id;
    logic [1:0]  status;
    logic        last;

    limit_order_matching u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .ord_id(ord_id), .limit_price(limit_price), .order_qty(order_qty),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .trade_price(trade_price), .trade_qty(trade_qty),
        .ask_id(ask_id), .bid_id(bid_id), .status(status), .last(last)
    );

    // The bench's own copy of the book.
    logic        book_live  [DEPTH];
    logic        book_ask   [DEPTH];
    logic [31:0] book_price [DEPTH];
    logic [31:0] book_qty   [DEPTH];
    logic [30:0] book_owner [DEPTH];
    logic [31:0] book_seq   [DEPTH];
    logic [31:0] seq_count;

    order_t  order_q[$];
    report_t report_q[$];
    int      errors;
    int      cur_phase;
    bit      stim_done;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic report_t mk(logic k, logic [31:0] p, logic [31:0] q,
                                   logic [30:0] a, logic [30:0] b, logic [1:0] s);
        report_t r;
        r.kind = k; r.price = p; r.qty = q; r.ask = a; r.bid = b; r.st = s;
        r.last = k;
        return r;
    endfunction

    // Best resting order on one side: best price first, then oldest arrival.
    function automatic int best_resting(logic want_ask);
        int best;
        best = -1;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (!book_live[i] || book_ask[i] != want_ask)
                continue;
            if (best < 0)
                best = i;
            else if (book_price[i] != book_price[best])
            begin
                if (want_ask ? (book_price[i] < book_price[best])
                             : (book_price[i] > book_price[best]))
                    best = i;
            end
            else if ((seq_count - book_seq[i]) > (seq_count - book_seq[best]))
                best = i;
        end
        return best;
    endfunction

    // Applies one accepted command to the book and queues the words it must produce.
    task automatic match_order(order_t o);
        logic        sell;
        logic [31:0] left;
        logic [31:0] fill;
        int          n;
        int          b;
        bit          placed;
        sell = (o.op == CMD_ASK);
        left = o.qty;
        n = 0;
        placed = 0;
        if (o.op == CMD_BAD)
        begin
            report_q.push_back(mk(KIND_DONE, '0, '0, '0, '0, ST_BADCMD));
            return;
        end
        if (o.op == CMD_CANCEL)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (book_live[i] && book_owner[i] == o.id)
                begin
                    book_live[i] = 1'b0;
                    report_q.push_back(mk(KIND_DONE, '0, '0, '0, '0, ST_OK));
                    return;
                end
            end
            report_q.push_back(mk(KIND_DONE, '0, '0, '0, '0, ST_UNKNOWN));
            return;
        end
        while (left != 0 && n < DEPTH)
        begin
            b = best_resting(!sell);
            if (b < 0)
                break;
            if (sell ? (book_price[b] < o.price) : (book_price[b] > o.price))
                break;
            fill = (book_qty[b] < left) ? book_qty[b] : left;
            if (sell)
                report_q.push_back(mk(KIND_TRADE, book_price[b], fill, o.id, book_owner[b],
                                      ST_OK));
            else
                report_q.push_back(mk(KIND_TRADE, book_price[b], fill, book_owner[b], o.id,
                                      ST_OK));
            n++;
            book_qty[b] -= fill;
            left -= fill;
            if (book_qty[b] == 0)
                book_live[b] = 1'b0;
        end
        if (left == 0)
        begin
            report_q.push_back(mk(KIND_DONE, '0, '0, '0, '0, ST_OK));
            return;
        end
        for (int i = 0; i < DEPTH && !placed; i++)
        begin
            if (!book_live[i])
            begin
                book_live[i] = 1'b1;
                book_ask[i] = sell;
                book_price[i] = o.price;
                book_qty[i] = left;
                book_owner[i] = o.id;
                book_seq[i] = seq_count;
                seq_count = seq_count + 32'd1;
                placed = 1;
            end
        end
        if (placed)
            report_q.push_back(mk(KIND_DONE, '0, left, '0, '0, ST_OK));
        else
            report_q.push_back(mk(KIND_DONE, '0, '0, '0, '0, ST_FULL));
    endtask

    // Percent of cycles in which the sender holds back, and the receiver stalls.
    function automatic int send_gap(int ph);
        return (ph == 1) ? 54 : (ph == 3) ? 33 : 0;
    endfunction

    function automatic int recv_gap(int ph);
        return (ph == 2) ? 54 : (ph == 3) ? 33 : 0;
    endfunction

    // Driver: the held word is predicted at the edge where it is taken, then the next
    // one is loaded unless the sender idles this cycle.
    always @(posedge clk or negedge rst_n)
    begin
        order_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cmd <= CMD_BID;
            ord_id <= '0;
            limit_price <= '0;
            order_qty <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                nxt.op = cmd; nxt.id = ord_id; nxt.price = limit_price;
                nxt.qty = order_qty; nxt.phase = cur_phase;
                match_order(nxt);
            end
            if (!in_valid || !in_stall)
            begin
                if (order_q.size() > 0 && $urandom_range(99) >= send_gap(order_q[0].phase))
                begin
                    nxt = order_q.pop_front();
                    cur_phase <= nxt.phase;
                    in_valid <= 1'b1;
                    cmd <= nxt.op;
                    ord_id <= nxt.id;
                    limit_price <= nxt.price;
                    order_qty <= nxt.qty;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // The receiver stalls at random according to the phase of the word last sent.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < recv_gap(cur_phase));
    end

    // Monitor: every word taken from the block is checked against the oldest expectation.
    always @(posedge clk)
    begin
        report_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (report_q.size() == 0)
            begin
                $display("%0t: unexpected word kind=%0d qty=%0d status=%0d", $time, kind,
                         trade_qty, status);
                errors++;
            end
            else
            begin
                e = report_q.pop_front();
                if (e.kind !== kind || e.price !== trade_price || e.qty !== trade_qty ||
                    e.ask !== ask_id || e.bid !== bid_id || e.st !== status ||
                    e.last !== last)
                begin
                    $display("%0t: mismatch expected kind=%0d price=%0d qty=%0d ask=%0d bid=%0d st=%0d last=%0d",
                             $time, e.kind, e.price, e.qty, e.ask, e.bid, e.st, e.last);
                    $display("%0t:          actual   kind=%0d price=%0d qty=%0d ask=%0d bid=%0d st=%0d last=%0d",
                             $time, kind, trade_price, trade_qty, ask_id, bid_id, status,
                             last);
                    errors++;
                end
            end
        end
    end

    // Watchdog: counts cycles with work pending in which neither side moves a word.
    always @(posedge clk)
    begin
        int quiet;
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (stim_done && report_q.size() == 0))
            quiet = 0;
        else
            quiet++;
        if (quiet >= IDLE_LIMIT)
        begin
            $display("FAIL limit_order_matching");
            $finish;
        end
    end

    int queued;

    task automatic add(logic [1:0] op, logic [30:0] id, logic [31:0] p, logic [31:0] q);
        order_t o;
        o.op = op; o.id = id; o.price = p; o.qty = q;
        // Four quarters of the run: no idling, sender idle, receiver stall, both.
        o.phase = (queued * 4 / ITEM_GOAL > 3) ? 3 : queued * 4 / ITEM_GOAL;
        order_q.push_back(o);
        queued++;
    endtask

    initial
    begin
        int r;
        int n;
        rst_n = 1'b0;
        errors = 0;
        queued = 0;
        cur_phase = 0;
        stim_done = 0;
        seq_count = '0;
        for (int i = 0; i < DEPTH; i++)
            book_live[i] = 1'b0;

        // Directed part: bad command, unknown cancel, zero quantity, time priority at an
        // equal price, partial fills, price and quantity extremes and duplicate ids.
        add(CMD_BAD, 31'd3, 32'd7, 32'd7);
        add(CMD_CANCEL, 31'd5, 32'd0, 32'd0);
        add(CMD_BID, 31'd6, 32'd100, 32'd0);
        add(CMD_BID, 31'd1, 32'd100, 32'd10);
        add(CMD_BID, 31'd2, 32'd100, 32'd5);
        add(CMD_ASK, 31'd3, 32'd90, 32'd12);
        add(CMD_ASK, 31'd4, 32'hFFFF_FFFF, 32'd7);
        add(CMD_BID, 31'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add(CMD_ASK, 31'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        add(CMD_CANCEL, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add(CMD_BID, 31'd9, 32'd50, 32'd1);
        add(CMD_BID, 31'd9, 32'd50, 32'd1);
        add(CMD_CANCEL, 31'd9, 32'd0, 32'd0);
        add(CMD_CANCEL, 31'd9, 32'd0, 32'd0);
        add(CMD_CANCEL, 31'd9, 32'd0, 32'd0);
        add(CMD_ASK, 31'd11, 32'd0, 32'd0);

        // Random part. Ids come mostly from a small pool so cancels and duplicates hit,
        // and prices from a narrow band so orders cross often.
        while (queued < ITEM_GOAL)
        begin
            r = $urandom_range(99);
            if (r < 6)
            begin
                // Fill the book until it overflows, then sweep it with one large ask.
                n = $urandom_range(33, 36);
                for (int k = 0; k < n; k++)
                    add(CMD_BID, 31'($urandom_range(40)), $urandom_range(1, 20),
                        $urandom_range(1, 5));
                add(CMD_ASK, 31'($urandom_range(40)), 32'd0, 32'hFFFF_FFFF);
            end
            else if (r < 12)
                add(2'($urandom_range(3)), 31'($urandom), $urandom, $urandom);
            else if (r < 40)
                add(CMD_BID, 31'($urandom_range(40)), $urandom_range(100, 115),
                    ($urandom_range(9) == 0) ? $urandom : $urandom_range(20));
            else if (r < 68)
                add(CMD_ASK, 31'($urandom_range(40)), $urandom_range(100, 115),
                    ($urandom_range(9) == 0) ? $urandom : $urandom_range(20));
            else if (r < 90)
                add(CMD_CANCEL, 31'($urandom_range(40)), $urandom, $urandom);
            else
                add(CMD_BAD, 31'($urandom), $urandom, $urandom);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        wait (order_q.size() == 0 && !in_valid && report_q.size() == 0);
        stim_done = 1;
        // Let any stray word surface before the verdict.
        repeat (300) @(posedge clk);
        if (errors == 0 && report_q.size() == 0)
            $display("PASS limit_order_matching");
        else
            $display("FAIL limit_order_matching");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+src
src/lom_pkg.sv
src/lom_ram.sv
src/limit_order_matching.sv
sim/tb_limit_order_matching.sv
